// ===== rtl/core/mdi_pkg.sv =====
// Package for the monthly to daily interpolation unit.
// Holds widths, calendar tables and the command type passed from front to back.
// No dependencies.
package mdi_pkg;

  localparam int DataW      = 32;
  localparam int DayW       = 9;
  localparam int MonW       = 4;
  localparam int OffW       = 5;
  localparam int DiffW      = DataW + 1;
  localparam int ProdW      = DataW + OffW;
  localparam int CntW       = 6;
  localparam int Months     = 12;
  localparam int QueueDepth = 2;

  localparam logic [DayW-1:0] LastDay = DayW'(364);

  // month lengths, December before and January after the year
  localparam logic [OffW-1:0] Len14 [14] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31
  };

  // first day of each month
  localparam logic [DayW-1:0] MonthStart [Months] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  localparam logic [MonW-1:0] LastMonth = MonW'(Months - 1);

  typedef struct packed {
    logic                   is_load;
    logic [MonW-1:0]        widx;
    logic signed [DataW-1:0] wdata;
    logic [MonW-1:0]        bidx;
    logic [MonW-1:0]        aidx;
    logic [OffW-1:0]        offset;
    logic [OffW-1:0]        divisor;
    logic [DayW-1:0]        day_number;
  } cmd_t;

endpackage

// ===== rtl/core/mdi_front.sv =====
// Front end: classifies an input item into a command for the back end.
// Finds month, half, neighbour indexes, offset and divisor. Uses mdi_pkg.
module mdi_front (
  input  logic                               opcode,
  input  logic [mdi_pkg::MonW-1:0]           month_index,
  input  logic signed [mdi_pkg::DataW-1:0]   month_value,
  input  logic [mdi_pkg::DayW-1:0]           day_index,
  output logic                               keep,
  output mdi_pkg::cmd_t                      cmd
);

  logic [mdi_pkg::DayW-1:0] day;
  logic [mdi_pkg::MonW-1:0] m;
  logic [mdi_pkg::DayW-1:0] rel;
  logic [mdi_pkg::OffW-1:0] j;
  logic [mdi_pkg::OffW-1:0] len;
  logic [mdi_pkg::OffW-1:0] prev;
  logic [mdi_pkg::OffW-1:0] next;
  logic                     first;
  logic [mdi_pkg::OffW:0]   dsum;

  always_comb begin
    day = (day_index > mdi_pkg::LastDay) ? mdi_pkg::LastDay : day_index;
    m = '0;
    for (int i = 1; i < mdi_pkg::Months; i++) begin
      if (day >= mdi_pkg::MonthStart[i]) m = mdi_pkg::MonW'(i);
    end
    rel   = day - mdi_pkg::MonthStart[m];
    j     = rel[mdi_pkg::OffW-1:0];
    prev  = mdi_pkg::Len14[m];
    len   = mdi_pkg::Len14[mdi_pkg::MonW'(m + 4'd1)];
    next  = mdi_pkg::Len14[mdi_pkg::MonW'(m + 4'd2)];
    first = {j, 1'b0} < {1'b0, len};
    dsum  = first ? ({1'b0, prev} + {1'b0, len}) : ({1'b0, len} + {1'b0, next});

    cmd.is_load    = !opcode;
    cmd.widx       = month_index;
    cmd.wdata      = month_value;
    cmd.day_number = day_index;
    cmd.divisor    = dsum[mdi_pkg::OffW:1];
    if (first) begin
      cmd.bidx   = (m == '0) ? mdi_pkg::LastMonth : m - 4'd1;
      cmd.aidx   = m;
      cmd.offset = j + (prev >> 1);
    end else begin
      cmd.bidx   = m;
      cmd.aidx   = (m == mdi_pkg::LastMonth) ? '0 : m + 4'd1;
      cmd.offset = j - (len >> 1);
    end
    keep = opcode || (month_index < mdi_pkg::MonW'(mdi_pkg::Months));
  end

endmodule

// ===== rtl/core/mdi_queue.sv =====
// Short command queue between front and back ends.
// Register based, one push and one pop per cycle. Uses mdi_pkg.
module mdi_queue #(
  parameter int DEPTH = mdi_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  mdi_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output mdi_pkg::cmd_t rd_cmd,
  output logic          empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  mdi_pkg::cmd_t   slots [DEPTH];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;

  assign full   = count == CntW'(DEPTH);
  assign empty  = count == '0;
  assign rd_cmd = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= (wptr == PtrW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (rd) rptr <= (rptr == PtrW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      if (wr && !rd) count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slots[wptr] <= wr_cmd;
  end

endmodule

// ===== rtl/core/mdi_back.sv =====
// Back end: month store, multiply, serial divide and output register.
// Executes loads and queries in order from the queue. Uses mdi_pkg.
module mdi_back (
  input  logic                               clk,
  input  logic                               rst,
  input  mdi_pkg::cmd_t                      head,
  input  logic                               q_empty,
  output logic                               q_pop,
  input  logic                               pop,
  output logic                               empty,
  output logic signed [mdi_pkg::DataW-1:0]   day_value,
  output logic [mdi_pkg::DayW-1:0]           day_number
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [mdi_pkg::DataW-1:0]  mem [mdi_pkg::Months];
  logic [mdi_pkg::Months-1:0] vld;
  logic [mdi_pkg::DataW-1:0]  rd_b;
  logic [mdi_pkg::DataW-1:0]  rd_a;
  logic                       vb;
  logic                       va;

  logic [mdi_pkg::OffW-1:0]   offset;
  logic [mdi_pkg::OffW-1:0]   divisor;
  logic [mdi_pkg::DayW-1:0]   day_num;
  logic [mdi_pkg::DataW-1:0]  base;
  logic [mdi_pkg::DiffW-1:0]  diff;
  logic                       neg;
  logic [mdi_pkg::ProdW-1:0]  mag;
  logic [mdi_pkg::OffW-1:0]   rem;
  logic [mdi_pkg::CntW-1:0]   cnt;
  logic                       out_valid;

  logic [mdi_pkg::DataW-1:0]  before_v;
  logic [mdi_pkg::DataW-1:0]  after_v;
  logic [mdi_pkg::DiffW-1:0]  abs_diff;
  logic [mdi_pkg::OffW:0]     trial;
  logic                       ge;
  logic [mdi_pkg::OffW-1:0]   rem_next;
  logic [mdi_pkg::ProdW:0]    quot;
  logic [mdi_pkg::DataW-1:0]  result;
  logic                       out_load;
  logic                       div_last;

  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign out_load = (state == S_DONE) && (!out_valid || pop);
  assign div_last = cnt == mdi_pkg::CntW'(mdi_pkg::ProdW - 1);

  always_comb begin
    before_v = vb ? rd_b : '0;
    after_v  = va ? rd_a : '0;
    abs_diff = diff[mdi_pkg::DiffW-1] ? -diff : diff;
    trial    = {rem, mag[mdi_pkg::ProdW-1]};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? mdi_pkg::OffW'(trial - {1'b0, divisor}) : trial[mdi_pkg::OffW-1:0];
    quot     = neg ? -{1'b0, mag} : {1'b0, mag};
    result   = base + quot[mdi_pkg::DataW-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_pop && !head.is_load) state_next = S_READ;
      S_READ: state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (div_last) state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (q_pop && head.is_load) vld[head.widx] <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (state == S_DIV) cnt <= cnt + 1'b1;
      else cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head.is_load) mem[head.widx] <= head.wdata;
    rd_b <= mem[head.bidx];
    rd_a <= mem[head.aidx];
    vb   <= vld[head.bidx];
    va   <= vld[head.aidx];
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        offset  <= head.offset;
        divisor <= head.divisor;
        day_num <= head.day_number;
      end
      S_READ: begin
        base <= before_v;
        diff <= {after_v[mdi_pkg::DataW-1], after_v} - {before_v[mdi_pkg::DataW-1], before_v};
      end
      S_MUL: begin
        neg <= diff[mdi_pkg::DiffW-1];
        mag <= mdi_pkg::ProdW'(abs_diff * offset);
        rem <= '0;
      end
      S_DIV: begin
        rem <= rem_next;
        mag <= {mag[mdi_pkg::ProdW-2:0], ge};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      day_value  <= result;
      day_number <= day_num;
    end
  end

endmodule

// ===== rtl/core/monthly_to_daily_interpolation_unit.sv =====
// Top level of the monthly to daily interpolation unit.
// Instantiates mdi_front, mdi_queue and mdi_back. Uses mdi_pkg.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  input     | push / full          | opcode, month_index, month_value, day_index
//  result    | pop / empty          | day_value, day_number
//
// A query passes through read, multiply and the one-bit-per-cycle restoring
// divider over the 37-bit product in mdi_back; a load is stored when popped.
// Reset (rst, synchronous) empties the queue and output register and marks all
// months as zero. The front accepts while the command queue has room, so items
// queue up while the back end divides or waits for pop.
module monthly_to_daily_interpolation_unit #(
  parameter int QUEUE_DEPTH = mdi_pkg::QueueDepth
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic                               opcode,
  input  logic [mdi_pkg::MonW-1:0]           month_index,
  input  logic signed [mdi_pkg::DataW-1:0]   month_value,
  input  logic [mdi_pkg::DayW-1:0]           day_index,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [mdi_pkg::DataW-1:0]   day_value,
  output logic [mdi_pkg::DayW-1:0]           day_number
);

  mdi_pkg::cmd_t front_cmd;
  mdi_pkg::cmd_t head;
  logic          keep;
  logic          q_empty;
  logic          q_pop;

  mdi_front u_front (
    .opcode      (opcode),
    .month_index (month_index),
    .month_value (month_value),
    .day_index   (day_index),
    .keep        (keep),
    .cmd         (front_cmd)
  );

  mdi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (push && !full && keep),
    .wr_cmd (front_cmd),
    .full   (full),
    .rd     (q_pop),
    .rd_cmd (head),
    .empty  (q_empty)
  );

  mdi_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .day_value  (day_value),
    .day_number (day_number)
  );

endmodule

// ===== tb/sv/tb_monthly_to_daily_interpolation_unit.sv =====
// Testbench for monthly_to_daily_interpolation_unit: loads month values, queries days,
// and checks every result against an in-bench interpolation model.
// Depends on mdi_pkg and the RTL of the unit.

typedef enum logic {
  OP_LOAD  = 1'b0,
  OP_QUERY = 1'b1
} mdi_op_e;

class daily_value_checker;

  typedef struct {
    logic signed [mdi_pkg::DataW-1:0] value;
    logic [mdi_pkg::DayW-1:0]         day;
  } day_result_t;

  localparam int NumMonths = 12;
  localparam int YearEnd   = 364;

  // month lengths with December in front and January behind
  int unsigned mlen [14] = '{31, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31};

  logic signed [mdi_pkg::DataW-1:0] month_vals [NumMonths];
  day_result_t pending_days [$];
  int errors;
  int loads;
  int queries;
  int checked;

  function new();
    foreach (month_vals[i]) month_vals[i] = '0;
    errors  = 0;
    loads   = 0;
    queries = 0;
    checked = 0;
  endfunction

  task report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    errors++;
  endtask

  function logic signed [mdi_pkg::DataW-1:0] interp_day(logic [mdi_pkg::DayW-1:0] day_raw);
    int unsigned day;
    int unsigned len;
    int unsigned prev;
    int unsigned nxt;
    int m;
    longint before_v;
    longint after_v;
    longint offset;
    longint div;
    longint q;
    longint res;
    day = (day_raw > YearEnd) ? YearEnd : day_raw;
    m = 0;
    while (m < NumMonths - 1 && day >= mlen[m+1]) begin
      day -= mlen[m+1];
      m++;
    end
    len = mlen[m+1];
    if (2 * day < len) begin
      prev     = mlen[m];
      before_v = month_vals[(m + NumMonths - 1) % NumMonths];
      after_v  = month_vals[m];
      offset   = longint'(day) + longint'(prev / 2);
      div      = longint'((prev + len) / 2);
    end else begin
      nxt      = mlen[m+2];
      before_v = month_vals[m];
      after_v  = month_vals[(m + 1) % NumMonths];
      offset   = longint'(day) - longint'(len / 2);
      div      = longint'((len + nxt) / 2);
    end
    q   = (offset * (after_v - before_v)) / div;
    res = before_v + q;
    return res[mdi_pkg::DataW-1:0];
  endfunction

  function void note_item(mdi_op_e op, logic [mdi_pkg::MonW-1:0] midx,
                          logic signed [mdi_pkg::DataW-1:0] mval,
                          logic [mdi_pkg::DayW-1:0] day);
    day_result_t r;
    if (op == OP_LOAD) begin
      loads++;
      if (midx < NumMonths) month_vals[midx] = mval;
    end else begin
      queries++;
      r.value = interp_day(day);
      r.day   = day;
      pending_days.push_back(r);
    end
  endfunction

  task check_item(logic signed [mdi_pkg::DataW-1:0] value, logic [mdi_pkg::DayW-1:0] day);
    day_result_t e;
    if (pending_days.size() == 0) begin
      report_mismatch($sformatf("unexpected result day_number=%0d day_value=%h", day, value));
    end else begin
      e = pending_days.pop_front();
      checked++;
      if (value !== e.value)
        report_mismatch($sformatf("day %0d: day_value %h, want %h", e.day, value, e.value));
      if (day !== e.day)
        report_mismatch($sformatf("day_number %0d, want %0d", day, e.day));
    end
  endtask

endclass

module tb_monthly_to_daily_interpolation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;
  localparam int HoldOffCycles = 500;
  localparam int DrainCycles = 100;
  localparam int RandomItems = 1800;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              push = 1'b0;
  logic                              full;
  logic                              opcode = OP_LOAD;
  logic [mdi_pkg::MonW-1:0]          month_index = '0;
  logic signed [mdi_pkg::DataW-1:0]  month_value = '0;
  logic [mdi_pkg::DayW-1:0]          day_index = '0;
  logic                              empty;
  logic                              pop = 1'b0;
  logic signed [mdi_pkg::DataW-1:0]  day_value;
  logic [mdi_pkg::DayW-1:0]          day_number;

  daily_value_checker sb = new();

  int  cycles = 0;
  int  full_stalls = 0;
  bit  hold_off_request = 1'b0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  monthly_to_daily_interpolation_unit dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .month_index(month_index),
    .month_value(month_value),
    .day_index  (day_index),
    .empty      (empty),
    .pop        (pop),
    .day_value  (day_value),
    .day_number (day_number)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_monthly_to_daily_interpolation_unit: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_item(mdi_op_e'(opcode), month_index, month_value, day_index);
      if (push && full) full_stalls++;
      if (pop && !empty) sb.check_item(day_value, day_number);
    end
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random pop gaps, plus one long hold-off on request
  initial begin : receiver
    int gap;
    int hold;
    gap  = 0;
    hold = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        hold = HoldOffCycles;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else if (gap > 0) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
        gap = pick_gap(rx_steady);
      end
    end
  end

  task automatic send_item(mdi_op_e op, logic [mdi_pkg::MonW-1:0] midx,
                           logic signed [mdi_pkg::DataW-1:0] mval,
                           logic [mdi_pkg::DayW-1:0] day);
    @(negedge clk);
    push        <= 1'b1;
    opcode      <= op;
    month_index <= midx;
    month_value <= mval;
    day_index   <= day;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    push <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (sb.pending_days.size() != 0) @(negedge clk);
  endtask

  task automatic load(logic [mdi_pkg::MonW-1:0] midx, logic signed [mdi_pkg::DataW-1:0] mval);
    send_item(OP_LOAD, midx, mval, 9'($urandom));
  endtask

  task automatic query(logic [mdi_pkg::DayW-1:0] day);
    send_item(OP_QUERY, 4'($urandom), $urandom, day);
  endtask

  task automatic random_item();
    int r;
    logic [mdi_pkg::MonW-1:0] mi;
    logic signed [mdi_pkg::DataW-1:0] mv;
    logic [mdi_pkg::DayW-1:0] dy;
    r  = $urandom_range(0, 99);
    mi = (r < 6) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
    r  = $urandom_range(0, 99);
    if (r < 5) mv = 32'sh7FFF_FFFF;
    else if (r < 10) mv = 32'sh8000_0000;
    else if (r < 30) mv = $signed($urandom_range(0, 131071)) - 65536;
    else mv = $urandom;
    r = $urandom_range(0, 99);
    if (r < 8) dy = 9'($urandom_range(365, 511));
    else if (r < 30) dy = mdi_pkg::MonthStart[$urandom_range(0, 11)]
                          + 9'($urandom_range(0, 1) * 15 + $urandom_range(0, 1));
    else if (r < 35) dy = mdi_pkg::MonthStart[$urandom_range(1, 11)] - 9'd1;
    else dy = 9'($urandom_range(0, 364));
    if ($urandom_range(0, 99) < 40) send_item(OP_LOAD, mi, mv, dy);
    else send_item(OP_QUERY, mi, mv, dy);
  endtask

  initial begin : stimulus
    int n;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: cleared store, extreme values, year wrap, out-of-range fields
    query(9'd100);
    load(4'd0, 32'sh7FFF_FFFF);
    load(4'd11, 32'sh8000_0000);
    query(9'd0);
    query(9'd15);
    query(9'd16);
    query(9'd364);
    query(9'd365);
    query(9'd511);
    load(4'd15, 32'sh1234_5678);
    load(4'd12, -32'sd1);
    load(4'd1, 32'sh8000_0000);
    query(9'd44);
    query(9'd45);
    query(9'd58);
    load(4'd2, 32'sh7FFF_FFFF);
    query(9'd59);
    query(9'd334);
    load(4'd6, 32'sh0001_0000);
    load(4'd5, -32'sh0001_0000);
    query(9'd181);
    query(9'd165);
    query(9'd196);
    wait_drained();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 300 == 0) begin
        tx_steady = ($urandom_range(0, 2) == 0);
        rx_steady = ($urandom_range(0, 2) == 0);
      end
      if (i == 600) begin
        // receiver holds off while queries keep coming, so the input backs up
        hold_off_request = 1'b1;
        for (int k = 0; k < 30; k++) query(9'($urandom_range(0, 511)));
      end
      if (i == 1200) wait_drained();
      random_item();
      n = pick_gap(tx_steady);
      if (n > 0) idle_input(n);
    end

    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    $display("%0d loads and %0d queries sent, %0d results checked, %0d cycles with input held off",
             sb.loads, sb.queries, sb.checked, full_stalls);
    if (sb.errors == 0 && sb.pending_days.size() == 0) begin
      $display("tb_monthly_to_daily_interpolation_unit: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_days.size());
      $display("tb_monthly_to_daily_interpolation_unit: errors");
    end
    $finish;
  end

endmodule
